@@ rtl/assert_macros.svh @@
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, off while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/fspa_pkg.sv @@
// Shared types and constants of the fixed slot pool allocator.
package fspa_pkg;

  localparam int SlotW   = 10;
  localparam int CountW  = 11;
  localparam int SizeW   = 13;
  localparam int OffsetW = 22;
  localparam int StatusW = 2;
  localparam int ProdW   = CountW + SizeW;

  localparam logic [OffsetW-1:0] OffsetMax = {OffsetW{1'b1}};

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [StatusW-1:0] STATUS_INVALID   = 2'd2;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  localparam logic REG_POOL_SLOTS  = 1'b0;
  localparam logic REG_SLICE_BYTES = 1'b1;

  localparam logic [CountW-1:0] PoolSlotsReset  = 11'd1024;
  localparam logic [SizeW-1:0]  SliceBytesReset = 13'd64;

  typedef logic [SlotW-1:0]   slot_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [StatusW-1:0] status_t;

endpackage

@@ rtl/fspa_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module fspa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fixed_slot_pool_allocator.sv @@
// Top level of the fixed slot pool allocator: free stack in RAM plus bump counter.
// Sequencing: a request accepted in idle is held in the request registers and
// executes in the execute state; a held result delays execution. No new request
// is accepted until the last one has executed, as the stack top read is registered.
// Reset: synchronous, clears the counters, the stack depth and the handshake
// state and loads register defaults; stack RAM contents stay undefined.
`include "assert_macros.svh"

module fixed_slot_pool_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] slot_index, [15:10] zero
  input  logic        s_tuser,   // [0] action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [9:0] granted_slot, [31:10] byte_offset,
                                 // [32] pool_full, [39:33] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int AddrW  = $clog2(MAX_SLOTS);
  localparam int DepthW = $clog2(MAX_SLOTS + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_SLOTS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Configuration registers
  fspa_pkg::count_t             pool_slots;
  logic [fspa_pkg::SizeW-1:0]   slice_bytes;

  // Allocator state
  logic                         state;
  fspa_pkg::count_t             next_unused;
  fspa_pkg::count_t             next_unused_next;
  logic [DepthW-1:0]            free_depth;
  logic [DepthW-1:0]            free_depth_next;

  // Request held between accept and execute
  logic                         req_action;
  fspa_pkg::slot_t              req_slot;

  // Result register
  logic                         out_valid;
  fspa_pkg::status_t            out_status;
  fspa_pkg::slot_t              out_slot;
  logic [fspa_pkg::OffsetW-1:0] out_offset;
  logic                         out_full;

  logic                         accept;
  logic                         fire;
  fspa_pkg::count_t             eff_slots;
  fspa_pkg::slot_t              stack_top;
  logic                         push;
  fspa_pkg::status_t            status_next;
  fspa_pkg::count_t             granted;
  logic [fspa_pkg::ProdW-1:0]   product;
  logic [fspa_pkg::OffsetW-1:0] offset_next;
  logic                         full_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  // Execute once the result register is free or being drained.
  assign fire     = (state == ST_EXEC) && (!out_valid || m_tready);

  // Clamp the slot count to the stack capacity.
  assign eff_slots = ({21'd0, pool_slots} > 32'(MAX_SLOTS)) ? fspa_pkg::CountW'(MAX_SLOTS)
                                                            : pool_slots;

  // Free stack: read the top at accept, push on a valid free.
  fspa_ram #(
    .WIDTH (fspa_pkg::SlotW),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (fire && push),
    .waddr (free_depth[AddrW-1:0]),
    .wdata (req_slot),
    .re    (accept),
    .raddr (AddrW'(free_depth - DepthW'(1))),
    .rdata (stack_top)
  );

  always_comb begin
    status_next      = fspa_pkg::STATUS_OK;
    granted          = '0;
    push             = 1'b0;
    next_unused_next = next_unused;
    free_depth_next  = free_depth;
    if (req_action == fspa_pkg::ACTION_ALLOC) begin
      if (free_depth != '0) begin
        // Pop the most recently freed slot.
        granted         = {1'b0, stack_top};
        free_depth_next = free_depth - DepthW'(1);
      end else if (next_unused < eff_slots) begin
        // Bump a never-used slot.
        granted          = next_unused;
        next_unused_next = next_unused + fspa_pkg::CountW'(1);
      end else begin
        status_next = fspa_pkg::STATUS_EXHAUSTED;
      end
    end else begin
      if (({1'b0, req_slot} >= next_unused) || ({1'b0, req_slot} >= eff_slots) ||
          (free_depth == DepthMax)) begin
        status_next = fspa_pkg::STATUS_INVALID;
      end else begin
        push            = 1'b1;
        free_depth_next = free_depth + DepthW'(1);
      end
    end
  end

  assign product     = granted * slice_bytes;
  assign offset_next = (product > fspa_pkg::ProdW'(fspa_pkg::OffsetMax)) ? fspa_pkg::OffsetMax
                                                         : product[fspa_pkg::OffsetW-1:0];
  assign full_next   = (free_depth_next == '0) && (next_unused_next >= eff_slots);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_slots  <= fspa_pkg::PoolSlotsReset;
      slice_bytes <= fspa_pkg::SliceBytesReset;
    end else if (cfg_we) begin
      case (cfg_index)
        fspa_pkg::REG_POOL_SLOTS:  pool_slots  <= cfg_data[fspa_pkg::CountW-1:0];
        fspa_pkg::REG_SLICE_BYTES: slice_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control: accept in idle, hold in execute until the result register frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      next_unused <= '0;
      free_depth  <= '0;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state       <= ST_IDLE;
            next_unused <= next_unused_next;
            free_depth  <= free_depth_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= s_tuser;
      req_slot   <= s_tdata[fspa_pkg::SlotW-1:0];
    end
    if (fire) begin
      out_status <= status_next;
      out_slot   <= granted[fspa_pkg::SlotW-1:0];
      out_offset <= offset_next;
      out_full   <= full_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'd0, out_full, out_offset, out_slot};

  // A transaction on the request side always moves the sequencer to execute.
  `ASSERT_RST(a_accept_exec, clk, rst, accept |=> (state == ST_EXEC))
  // The stack never holds more entries than it has rows.
  `ASSERT_RST(a_depth_bound, clk, rst, free_depth <= DepthMax)
  // A failed allocate grants nothing.
  `ASSERT_RST(a_fail_zero, clk, rst,
    (m_tvalid && (m_tuser == fspa_pkg::STATUS_EXHAUSTED)) |-> (m_tdata[31:0] == 32'd0))
  // A full pool in a pending result matches an empty free stack.
  `ASSERT_RST(a_full_empty, clk, rst, (m_tvalid && m_tdata[32]) |-> (free_depth == '0))

endmodule

@@ sim/tb_fixed_slot_pool_allocator.sv @@
// Self-checking testbench for the fixed slot pool allocator.
module tb_fixed_slot_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH = 1024;
  // Time limit: far beyond the slowest legal run of this stimulus.
  localparam int LIMIT_NS   = 2_000_000;
  localparam int HOLD_OFF   = 300;

  // One request as queued for the driver. drain_first makes the driver hold
  // this request back until every pending grant has been checked.
  typedef struct {
    logic            action;
    fspa_pkg::slot_t slot_index;
    bit              drain_first;
  } pool_req_t;

  // Expected grant of one request.
  typedef struct {
    fspa_pkg::status_t            status;
    fspa_pkg::slot_t              granted;
    logic [fspa_pkg::OffsetW-1:0] offset;
    logic                         full;
  } pool_grant_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [fspa_pkg::SizeW-1:0] cfg_data  = '0;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [15:0]                s_tdata   = '0;   // [9:0] slot_index, [15:10] zero
  logic                       s_tuser   = 1'b0; // [0] action
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [39:0]                m_tdata;          // [9:0] granted_slot, [31:10] byte_offset,
                                                // [32] pool_full, [39:33] zero
  logic [1:0]                 m_tuser;          // [1:0] status

  fixed_slot_pool_allocator #(.MAX_SLOTS(POOL_DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Allocator shadow state: registers, bump counter and LIFO free stack.
  fspa_pkg::count_t           cfg_pool_slots  = fspa_pkg::PoolSlotsReset;
  logic [fspa_pkg::SizeW-1:0] cfg_slice_bytes = fspa_pkg::SliceBytesReset;
  int                         next_unused     = 0;
  int                         stack_depth     = 0;
  fspa_pkg::slot_t            free_stack [POOL_DEPTH];

  pool_req_t   req_q[$];    // requests waiting for the driver
  pool_grant_t grant_q[$];  // grants owed by the block, oldest first
  pool_req_t   offer;       // request currently driven on the slave side

  bit req_fired   = 1'b0;   // slave-side transaction at the last rising edge
  bit grant_fired = 1'b0;   // master-side transaction at the last rising edge
  bit calm        = 1'b0;   // no idling on either side while set
  int send_gap    = 0;
  int take_gap    = 0;
  int hold_ask    = 0;      // long receiver hold-off requested by the stimulus
  int hold_left   = 0;
  int errors      = 0;
  int grants_seen = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Advance the shadow allocator by one request and return the grant it owes.
  function automatic pool_grant_t predict_grant(pool_req_t rq);
    pool_grant_t g;
    int          usable;
    int          prod;
    g.status  = fspa_pkg::STATUS_OK;
    g.granted = '0;
    g.offset  = '0;
    usable = (cfg_pool_slots > POOL_DEPTH) ? POOL_DEPTH : int'(cfg_pool_slots);
    if (rq.action == fspa_pkg::ACTION_ALLOC) begin
      // Reuse the most recently freed slot first, then bump.
      if (stack_depth > 0) begin
        stack_depth--;
        g.granted = free_stack[stack_depth];
      end else if (next_unused < usable) begin
        g.granted = fspa_pkg::slot_t'(next_unused);
        next_unused++;
      end else begin
        g.status = fspa_pkg::STATUS_EXHAUSTED;
      end
      if (g.status == fspa_pkg::STATUS_OK) begin
        prod = int'(g.granted) * int'(cfg_slice_bytes);
        g.offset = (prod > int'(fspa_pkg::OffsetMax)) ? fspa_pkg::OffsetMax
                                                      : prod[fspa_pkg::OffsetW-1:0];
      end
    end else if (rq.slot_index >= next_unused || rq.slot_index >= usable ||
                 stack_depth >= POOL_DEPTH) begin
      // Never handed out, beyond the pool, or no room left on the stack.
      g.status = fspa_pkg::STATUS_INVALID;
    end else begin
      free_stack[stack_depth] = rq.slot_index;
      stack_depth++;
    end
    g.full = (stack_depth == 0 && next_unused >= usable);
    return g;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 9);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on grant %0d: %s got %0h want %0h", grants_seen, what, got, want);
  endtask

  // Record handshakes, predict on every accepted request and check every
  // accepted grant against the oldest prediction.
  always @(posedge clk) begin
    pool_grant_t want;
    req_fired   = s_tvalid && s_tready;
    grant_fired = m_tvalid && m_tready;
    if (!rst && req_fired)
      grant_q.push_back(predict_grant(offer));
    if (!rst && grant_fired) begin
      if (grant_q.size() == 0) begin
        report_mismatch("grant with no request pending", {30'b0, m_tuser}, '0);
      end else begin
        want = grant_q.pop_front();
        if (m_tuser !== want.status)
          report_mismatch("status", {30'b0, m_tuser}, {30'b0, want.status});
        if (m_tdata[9:0] !== want.granted)
          report_mismatch("granted_slot", {22'b0, m_tdata[9:0]}, {22'b0, want.granted});
        if (m_tdata[31:10] !== want.offset)
          report_mismatch("byte_offset", {10'b0, m_tdata[31:10]}, {10'b0, want.offset});
        if (m_tdata[32] !== want.full)
          report_mismatch("pool_full", {31'b0, m_tdata[32]}, {31'b0, want.full});
      end
      grants_seen++;
    end
  end

  // Driver: hold the current request until taken, then wait a drawn number of
  // cycles before offering the next one.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_fired) begin
      if (req_fired) send_gap = draw_wait();
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (req_q.size() > 0 && !(req_q[0].drain_first && grant_q.size() > 0)) begin
        offer = req_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, offer.slot_index};
        s_tuser  <= offer.action;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall a drawn number of cycles after each grant; on request
  // drop ready for a long stretch so the block backs up into its input.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask  = 0;
      end
      if (grant_fired) take_gap = draw_wait();
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(logic act, int slot, bit drain = 1'b0);
    pool_req_t r;
    r.action      = act;
    r.slot_index  = fspa_pkg::slot_t'(slot);
    r.drain_first = drain;
    req_q.push_back(r);
  endtask

  // Block until every queued request is taken and every grant checked.
  // Sample at the rising edge, where the driver's queue and valid are settled.
  task automatic wait_idle();
    do @(posedge clk);
    while (req_q.size() != 0 || s_tvalid || grant_q.size() != 0);
  endtask

  task automatic write_reg(logic idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= fspa_pkg::SizeW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fspa_pkg::REG_POOL_SLOTS) cfg_pool_slots = fspa_pkg::CountW'(val);
    else cfg_slice_bytes = fspa_pkg::SizeW'(val);
  endtask

  // Reconfigure only once the block has drained.
  task automatic set_pool(int slots, int bytes);
    wait_idle();
    write_reg(fspa_pkg::REG_POOL_SLOTS, slots);
    write_reg(fspa_pkg::REG_SLICE_BYTES, bytes);
  endtask

  // Mostly well-formed traffic: frees of slots that have been handed out, with
  // some frees of arbitrary indexes as noise. Optionally pause the sender
  // halfway until every grant so far has come back.
  task automatic random_phase(int n, int alloc_pct, bit pause_mid);
    int hi;
    int k;
    bit drain_here;
    hi = next_unused;
    for (k = 0; k < n; k++) begin
      drain_here = pause_mid && (k == n / 2);
      if ($urandom_range(1, 100) <= alloc_pct) begin
        push_req(fspa_pkg::ACTION_ALLOC, $urandom_range(0, POOL_DEPTH - 1), drain_here);
        if (hi < POOL_DEPTH) hi++;
      end else if ($urandom_range(0, 3) != 0) begin
        push_req(fspa_pkg::ACTION_FREE, $urandom_range(0, (hi > 0) ? hi - 1 : 0),
                 drain_here);
      end else begin
        push_req(fspa_pkg::ACTION_FREE, $urandom_range(0, POOL_DEPTH - 1), drain_here);
      end
    end
  endtask

  // Double-free handed-out slots until the free stack overflows, then pop a few.
  task automatic flood_stack();
    int k;
    int reach;
    reach = POOL_DEPTH - stack_depth + 3;
    for (k = 0; k < reach; k++)
      push_req(fspa_pkg::ACTION_FREE, $urandom_range(0, next_unused - 1));
    for (k = 0; k < 4; k++)
      push_req(fspa_pkg::ACTION_ALLOC, $urandom_range(0, POOL_DEPTH - 1));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: frees before any grant, LIFO reuse, double free.
    push_req(fspa_pkg::ACTION_FREE, 0);
    push_req(fspa_pkg::ACTION_FREE, POOL_DEPTH - 1);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_ALLOC, POOL_DEPTH - 1);
    push_req(fspa_pkg::ACTION_FREE, 1);
    push_req(fspa_pkg::ACTION_FREE, 0);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_FREE, 1);
    push_req(fspa_pkg::ACTION_FREE, 1);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_ALLOC, 0);

    // Tiny pool at the largest legal slot size: exhaust it, free out of range.
    set_pool(3, 4096);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_FREE, 2);
    push_req(fspa_pkg::ACTION_FREE, 5);
    push_req(fspa_pkg::ACTION_ALLOC, 0);

    // Pool shrunk below the bump counter; the stack still hands out.
    set_pool(1, 0);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_FREE, 0);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_FREE, 2);

    // Empty pool.
    set_pool(0, 1);
    push_req(fspa_pkg::ACTION_ALLOC, 0);
    push_req(fspa_pkg::ACTION_FREE, 0);

    // Slot count above the maximum clamps; oversized slice.
    set_pool(2047, 8191);
    push_req(fspa_pkg::ACTION_ALLOC, 0);

    // Random part: climb the bump counter, then mix frees and allocates
    // under changing pool sizes and slot sizes.
    set_pool(POOL_DEPTH, 4096);
    calm = 1'b0;
    random_phase(120, 95, 1'b1);

    set_pool(7, 1);
    calm = 1'b1;
    random_phase(40, 50, 1'b1);

    set_pool(2047, 8191);
    calm = 1'b0;
    random_phase(60, 95, 1'b1);

    set_pool(POOL_DEPTH, $urandom_range(1, 8191));
    calm = 1'b1;
    flood_stack();

    set_pool(0, 0);
    calm = 1'b0;
    random_phase(30, 50, 1'b1);

    // Long receiver hold-off while the sender keeps offering.
    set_pool($urandom_range(1, 2047), $urandom_range(0, 8191));
    hold_ask = HOLD_OFF;
    random_phase(40, 50, 1'b1);

    set_pool(1, 8191);
    calm = 1'b1;
    random_phase(30, 50, 1'b0);

    set_pool(fspa_pkg::PoolSlotsReset, fspa_pkg::SliceBytesReset);
    calm = 1'b0;
    random_phase(30, 60, 1'b1);

    set_pool($urandom_range(0, 2047), $urandom_range(0, 8191));
    random_phase(30, 50, 1'b1);

    // Drain, then keep checking for stray grants before the verdict.
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/fspa_pkg.sv
rtl/fspa_ram.sv
rtl/fixed_slot_pool_allocator.sv
sim/tb_fixed_slot_pool_allocator.sv
